@@ src/cdq_pkg.sv @@
// Shared types and constants for the circular deque unit.
package cdq_pkg;

  localparam int DEPTH   = 8;
  localparam int WORD_W  = 32;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OCC_W   = 4;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [KIND_W-1:0] {
    REQ_PUSH_FRONT  = 2'd0,
    REQ_PUSH_BACK   = 2'd1,
    REQ_REMOVE_FRONT = 2'd2,
    REQ_REMOVE_BACK = 2'd3
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Decision for one request, from the pointer unit to the top level.
  typedef struct packed {
    status_t          status;
    logic             wr_en;
    logic             rd_en;
    ptr_t             addr;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
    logic             is_full;
  } plan_t;

endpackage

@@ src/cdq_if.sv @@
// Handshake channel interfaces for requests and responses.
interface cdq_req_if;
  import cdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        req_type;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface cdq_rsp_if;
  import cdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] removed_value;
  logic [OCC_W-1:0]         occupancy;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output status, output removed_value, output occupancy,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input removed_value, input occupancy,
                  input is_empty, input is_full, output ready);
endinterface

@@ src/cdq_ram.sv @@
// Single-port synchronous RAM with registered read data.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/cdq_ptr.sv @@
// Front/rear pointers and word count; decides the outcome of each request.
module cdq_ptr (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      upd,
  input  logic [cdq_pkg::KIND_W-1:0] req_type,
  output cdq_pkg::plan_t            plan
);
  import cdq_pkg::*;

  ptr_t front, front_next;
  ptr_t rear, rear_next;
  cnt_t count, count_next;
  logic full, empty;

  function automatic ptr_t ptr_up(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic ptr_t ptr_dn(input ptr_t p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    front_next  = front;
    rear_next   = rear;
    count_next  = count;
    plan.status = STAT_DONE;
    plan.wr_en  = 1'b0;
    plan.rd_en  = 1'b0;
    plan.addr   = front;
    case (req_kind_t'(req_type))
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) begin
          plan.status = STAT_FULL;
        end else begin
          plan.wr_en = 1'b1;
          count_next = count + CNT_W'(1);
          if (empty) begin
            // first word always lands in entry zero
            front_next = '0;
            rear_next  = '0;
            plan.addr  = '0;
          end else if (req_kind_t'(req_type) == REQ_PUSH_FRONT) begin
            front_next = ptr_dn(front);
            plan.addr  = front_next;
          end else begin
            rear_next = ptr_up(rear);
            plan.addr = rear_next;
          end
        end
      end
      REQ_REMOVE_FRONT, REQ_REMOVE_BACK: begin
        if (empty) begin
          plan.status = STAT_EMPTY;
        end else begin
          plan.rd_en = 1'b1;
          count_next = count - CNT_W'(1);
          if (req_kind_t'(req_type) == REQ_REMOVE_FRONT) begin
            plan.addr = front;
            if (count > CNT_W'(1)) front_next = ptr_up(front);
          end else begin
            plan.addr = rear;
            if (count > CNT_W'(1)) rear_next = ptr_dn(rear);
          end
        end
      end
      default: ;
    endcase
    plan.occupancy = OCC_W'(count_next);
    plan.is_empty  = (count_next == '0);
    plan.is_full   = (count_next == CNT_W'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
    end else if (upd) begin
      front <= front_next;
      rear  <= rear_next;
      count <= count_next;
    end
  end

endmodule

@@ src/circular_deque_unit.sv @@
// Top level of the circular deque unit: request/response channels, ring memory, sequencing.
//
// A double-ended queue of DEPTH signed 32-bit words held in a single-port ring
// memory. Each request pushes a word at the front or back, or removes the word
// at the front or back; every request yields exactly one response with a
// status (done, full, empty), the removed word (zero unless a removal
// succeeded), and the occupancy with empty and full flags after the request.
// Timing: the response to a push or a refused request is in the output
// register on the next edge. A successful removal first passes through the
// registered read of the ring memory (state S_READ); no new request is
// taken while that read is in flight. A new request is taken while a finished
// response waits only if the response is being taken in the same cycle.
// The memory needs no clearing after reset: only written entries are read.
module circular_deque_unit (
  input  logic       clk,
  input  logic       rst,
  cdq_req_if.sink    req,
  cdq_rsp_if.source  rsp
);
  import cdq_pkg::*;

  state_t state, state_next;
  plan_t  plan;
  logic   accept;
  word_t  rdata;

  // output register
  logic             out_valid;
  status_t          out_status;
  word_t            out_removed;
  logic [OCC_W-1:0] out_occ;
  logic             out_empty;
  logic             out_full;

  // Pointer bookkeeping; commits only on an accepted item.
  cdq_ptr u_ptr (
    .clk      (clk),
    .rst      (rst),
    .upd      (accept),
    .req_type (req.req_type),
    .plan     (plan)
  );

  // Ring store: write on a push, read on every access (used for removals).
  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && plan.wr_en),
    .addr  (plan.addr),
    .wdata (word_t'(req.push_value)),
    .rdata (rdata)
  );

  assign accept = req.valid && req.ready;

  // Sequencer: hold off new items while a removal read is pending, and
  // while the output register is occupied and not draining.
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = !out_valid || rsp.ready;
        if (req.valid && req.ready && plan.rd_en) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: drop when taken, raise on a finished item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && !plan.rd_en) begin
      out_valid <= 1'b1;
    end else if (state == S_READ) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload: status and counts are known at accept; the removed word
  // arrives from memory in the cycle after, while in state S_READ.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status  <= plan.status;
      out_removed <= '0;
      out_occ     <= plan.occupancy;
      out_empty   <= plan.is_empty;
      out_full    <= plan.is_full;
    end else if (state == S_READ) begin
      out_removed <= rdata;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.removed_value = out_removed;
  assign rsp.occupancy     = out_occ;
  assign rsp.is_empty      = out_empty;
  assign rsp.is_full       = out_full;

  // A successful removal shows its response once the S_READ state has passed.
  a_remove_latency: assert property (@(posedge clk) disable iff (rst)
    accept && plan.rd_en |-> ##2 rsp.valid)
    else $error("removal response not delivered on time");

  // A push that is taken reports done on the next edge.
  a_push_done: assert property (@(posedge clk) disable iff (rst)
    accept && plan.wr_en |=> rsp.valid && rsp.status == STAT_DONE)
    else $error("push response missing or wrong status");

  // A refused item carries a zero word and a refusal status.
  a_refused: assert property (@(posedge clk) disable iff (rst)
    accept && !plan.wr_en && !plan.rd_en |=>
      rsp.valid && rsp.removed_value == '0 && rsp.status != STAT_DONE)
    else $error("refused request reported wrongly");

  // The output register is free while a memory read is in flight.
  a_read_slot: assert property (@(posedge clk) disable iff (rst)
    !(state == S_READ && out_valid))
    else $error("output register busy during removal read");

endmodule
